@@ design/ordered_set_query_engine_macros.svh @@
// ----------------------------------------------------------------------------
// Ordered set query engine assertion macros
// Shorthand for the concurrent checks of the engine, clocked by clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SET_QUERY_ENGINE_MACROS_SVH
`define ORDERED_SET_QUERY_ENGINE_MACROS_SVH

// The condition holds at every clock edge.
`define OSQ_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define OSQ_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds at the edge after the antecedent.
`define OSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/osq_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered set query engine package
// Shared types and codes of the engine, its cells and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package osq_pkg;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] osq_value_type;

   typedef enum logic [2:0] {
      ACT_INSERT      = 3'd0,
      ACT_DELETE      = 3'd1,
      ACT_MIN         = 3'd2,
      ACT_MAX         = 3'd3,
      ACT_SUCC_STRICT = 3'd4,
      ACT_SUCC_EQ     = 3'd5,
      ACT_PRED_STRICT = 3'd6,
      ACT_PRED_EQ     = 3'd7
   } osq_action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_NONE  = 2'd2,
      STAT_FULL  = 2'd3
   } osq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_REDUCE,
      ST_DECIDE
   } osq_state_type;

   typedef struct packed {
      osq_action_type action;
      logic           compare;
      logic           shift_in;
      logic           shift_out;
   } osq_cell_ctrl_type;

   typedef struct packed {
      logic          hit;
      osq_value_type value;
   } osq_leaf_type;

endpackage

`default_nettype wire

@@ design/osq_if.sv @@
// ----------------------------------------------------------------------------
// Ordered set query engine channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface osq_req_if
   import osq_pkg::*;
();
   logic           valid;
   logic           ready;
   osq_action_type action;
   osq_value_type  operand;

   modport source (output valid, output action, output operand, input ready);
   modport sink (input valid, input action, input operand, output ready);
endinterface

interface osq_rsp_if
   import osq_pkg::*;
();
   logic           valid;
   logic           ready;
   osq_value_type  answer;
   osq_status_type status;

   modport source (output valid, output answer, output status, input ready);
   modport sink (input valid, input answer, input status, output ready);
endinterface

`default_nettype wire

@@ design/osq_cell.sv @@
// ----------------------------------------------------------------------------
// Ordered set query engine cell
// Holds one value of the sorted row, compares it with the key, picks itself
// out for a query and shifts with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module osq_cell
   import osq_pkg::*;
(
   input  logic              clock,
   input  osq_cell_ctrl_type ctrl,
   input  osq_value_type     key,
   input  logic              occupied,
   input  logic              prev_occ,
   input  logic              prev_lt,
   input  logic              prev_le,
   input  osq_value_type     prev_value,
   input  logic              next_occ,
   input  logic              next_lt,
   input  logic              next_le,
   input  osq_value_type     next_value,
   output logic              lt_out,
   output logic              le_out,
   output osq_value_type     value_out,
   output osq_leaf_type      leaf
);

   osq_value_type value_ff, value_in;
   logic          lt_ff, lt_in;
   logic          le_ff, le_in;
   logic          lt_eff, le_eff, sel;

   always_comb begin
      lt_eff = lt_ff & occupied;
      le_eff = le_ff & occupied;
      lt_in  = ctrl.compare ? (value_ff < key) : lt_ff;
      le_in  = ctrl.compare ? (value_ff <= key) : le_ff;

      value_in = value_ff;
      if (ctrl.shift_in && !lt_eff) begin
         value_in = prev_lt ? key : prev_value;
      end else if (ctrl.shift_out && !lt_eff) begin
         value_in = next_value;
      end

      case (ctrl.action) inside
         ACT_INSERT, ACT_DELETE, ACT_SUCC_EQ: sel = occupied & ~lt_eff & prev_lt;
         ACT_MIN:         sel = occupied & ~prev_occ;
         ACT_MAX:         sel = occupied & ~next_occ;
         ACT_SUCC_STRICT: sel = occupied & ~le_eff & prev_le;
         ACT_PRED_STRICT: sel = lt_eff & ~next_lt;
         ACT_PRED_EQ:     sel = le_eff & ~next_le;
         default:         sel = 1'b0;
      endcase

      leaf.hit   = sel;
      leaf.value = sel ? value_ff : '0;
      lt_out     = lt_eff;
      le_out     = le_eff;
      value_out  = value_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      le_ff    <= le_in;
   end

endmodule

`default_nettype wire

@@ design/osq_or_tree.sv @@
// ----------------------------------------------------------------------------
// Ordered set query engine selection tree
// Registered OR tree that collects the single selected cell's leaf, one
// tree level per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module osq_or_tree #(
   parameter int LEAVES = 1024,
   parameter int WIDTH  = 33
) (
   input  logic                         clock,
   input  logic [LEAVES-1:0][WIDTH-1:0] leaf,
   output logic [WIDTH-1:0]             root
);

   localparam int LEVELS = $clog2(LEAVES);
   localparam int SPAN   = 1 << LEVELS;

   logic [WIDTH-1:0] node_ff [1:SPAN-1];
   logic [WIDTH-1:0] node_in [1:SPAN-1];

   for (genvar k = 1; k < SPAN; k++) begin : g_node
      logic [WIDTH-1:0] left, right;

      if (2 * k >= SPAN) begin : g_bottom
         if (2 * k - SPAN < LEAVES) begin : g_left
            assign left = leaf[2 * k - SPAN];
         end else begin : g_left_pad
            assign left = '0;
         end
         if (2 * k + 1 - SPAN < LEAVES) begin : g_right
            assign right = leaf[2 * k + 1 - SPAN];
         end else begin : g_right_pad
            assign right = '0;
         end
      end else begin : g_inner
         assign left  = node_ff[2 * k];
         assign right = node_ff[2 * k + 1];
      end

      assign node_in[k] = left | right;

      always_ff @(posedge clock) begin
         node_ff[k] <= node_in[k];
      end
   end

   assign root = node_ff[1];

endmodule

`default_nettype wire

@@ design/ordered_set_query_engine.sv @@
// ----------------------------------------------------------------------------
// Ordered set query engine
// Keeps a sorted set of distinct signed 32-bit values in a row of cells and
// answers insert, delete, minimum, maximum, successor and predecessor
// transactions, one response per request.
// ----------------------------------------------------------------------------
// The engine works on one request at a time. A request accepted at one edge
// is compared against every held value in the next cycle, then the selected
// cell is collected through a registered OR tree of $clog2(CAPACITY) levels,
// and a decide step sets the response and shifts the row. The decide step
// waits while an earlier response is still held, and a new request is taken
// only once the decide step is done. A finished response waits in an output
// register while the next request is already being worked on. No clearing
// pass follows reset.
`default_nettype none

module ordered_set_query_engine
   import osq_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic   clock,
   input  logic   reset,
   osq_req_if.sink   req_chan,
   osq_rsp_if.source rsp_chan
);

`include "ordered_set_query_engine_macros.svh"

   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int TREE_LEVELS = $clog2(CAPACITY);
   localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

   osq_state_type   state_ff, state_in;
   osq_action_type  action_ff, action_in;
   osq_value_type   operand_ff, operand_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LVL_W-1:0] wait_ff, wait_in;
   logic            rsp_valid_ff, rsp_valid_in;
   osq_value_type   answer_ff, answer_in;
   osq_status_type  status_ff, status_in;

   osq_cell_ctrl_type          cell_ctrl;
   logic [CAPACITY-1:0]        occ, lt_vec, le_vec, hit_vec;
   osq_value_type              value_q [CAPACITY];
   osq_leaf_type [CAPACITY-1:0] leaf_vec;
   osq_leaf_type               tree_root;
   logic                       slot_free, present, full;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic          p_occ, p_lt, p_le, n_occ, n_lt, n_le;
      osq_value_type p_val, n_val;

      if (i == 0) begin : g_head
         assign p_occ = 1'b0;
         assign p_lt  = 1'b1;
         assign p_le  = 1'b1;
         assign p_val = operand_ff;
      end else begin : g_prev
         assign p_occ = occ[i-1];
         assign p_lt  = lt_vec[i-1];
         assign p_le  = le_vec[i-1];
         assign p_val = value_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign n_occ = 1'b0;
         assign n_lt  = 1'b0;
         assign n_le  = 1'b0;
         assign n_val = '0;
      end else begin : g_next
         assign n_occ = occ[i+1];
         assign n_lt  = lt_vec[i+1];
         assign n_le  = le_vec[i+1];
         assign n_val = value_q[i+1];
      end

      assign occ[i] = CNT_W'(i) < count_ff;

      osq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .key        (operand_ff),
         .occupied   (occ[i]),
         .prev_occ   (p_occ),
         .prev_lt    (p_lt),
         .prev_le    (p_le),
         .prev_value (p_val),
         .next_occ   (n_occ),
         .next_lt    (n_lt),
         .next_le    (n_le),
         .next_value (n_val),
         .lt_out     (lt_vec[i]),
         .le_out     (le_vec[i]),
         .value_out  (value_q[i]),
         .leaf       (leaf_vec[i])
      );

      assign hit_vec[i] = leaf_vec[i].hit;
   end

   osq_or_tree #(
      .LEAVES (CAPACITY),
      .WIDTH  ($bits(osq_leaf_type))
   ) u_tree (
      .clock (clock),
      .leaf  (leaf_vec),
      .root  (tree_root)
   );

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.answer = answer_ff;
   assign rsp_chan.status = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      operand_ff <= operand_in;
      answer_ff  <= answer_in;
      status_ff  <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      operand_in   = operand_ff;
      count_in     = count_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      answer_in    = answer_ff;
      status_in    = status_ff;

      cell_ctrl.action    = action_ff;
      cell_ctrl.compare   = 1'b0;
      cell_ctrl.shift_in  = 1'b0;
      cell_ctrl.shift_out = 1'b0;

      slot_free = ~rsp_valid_ff | rsp_chan.ready;
      present   = tree_root.hit && (tree_root.value == operand_ff);
      full      = (count_ff == CNT_W'(CAPACITY));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               action_in  = req_chan.action;
               operand_in = req_chan.operand;
               state_in   = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cell_ctrl.compare = 1'b1;
            wait_in           = '0;
            state_in          = ST_REDUCE;
         end
         ST_REDUCE: begin
            wait_in = wait_ff + LVL_W'(1);
            if (wait_ff == LVL_W'(TREE_LEVELS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               answer_in    = '0;
               status_in    = STAT_OK;
               state_in     = ST_IDLE;
               case (action_ff)
                  ACT_INSERT: begin
                     if (!present) begin
                        if (full) begin
                           status_in = STAT_FULL;
                        end else begin
                           cell_ctrl.shift_in = 1'b1;
                           count_in           = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  ACT_DELETE: begin
                     if (present) begin
                        cell_ctrl.shift_out = 1'b1;
                        count_in            = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else if (tree_root.hit) begin
                        answer_in = tree_root.value;
                     end else begin
                        status_in = STAT_NONE;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `OSQ_ASSERT_HOLDS(a_count_bound, count_ff <= CNT_W'(CAPACITY), "Element count exceeds capacity.")
   `OSQ_ASSERT_IMPLIES(a_single_select, state_ff == ST_REDUCE, $onehot0(hit_vec), "More than one cell is selected.")
   `OSQ_ASSERT_NEXT(a_count_on_decide, state_ff != ST_DECIDE, $stable(count_ff), "Element count changed outside the decide step.")
   `OSQ_ASSERT_IMPLIES(a_rsp_from_decide, $rose(rsp_valid_ff), $past(state_ff) == ST_DECIDE, "A response appeared without a decide step.")
   `OSQ_ASSERT_IMPLIES(a_full_status, rsp_valid_ff && status_ff == STAT_FULL, count_ff == CNT_W'(CAPACITY), "Full status reported while the set is not full.")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered set query engine testbench
// Streams directed and random insert, delete and neighbor-query transactions
// into the engine under random stalls, predicts every response from an
// in-order copy of the set, and compares each response field by field.
// ----------------------------------------------------------------------------

module testbench;
   import osq_pkg::*;

   localparam int SET_CAPACITY   = 1024;
   localparam int ENGINE_LATENCY = $clog2(SET_CAPACITY) + 3;
   localparam int IDLE_PCT       = 29;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT   = 10;

   localparam osq_value_type VAL_MIN   = 32'sh80000000;
   localparam osq_value_type VAL_MAX   = 32'sh7FFFFFFF;
   localparam osq_value_type VAL_ONES  = 32'shFFFFFFFF;
   localparam osq_value_type VAL_ALT_A = 32'sh55555555;
   localparam osq_value_type VAL_ALT_B = 32'shAAAAAAAA;

   typedef struct {
      osq_action_type action;
      osq_value_type  operand;
   } set_request_type;

   typedef struct {
      osq_action_type action;
      osq_value_type  operand;
      osq_value_type  answer;
      osq_status_type status;
   } set_answer_type;

   logic clock;
   logic reset;

   osq_req_if req_if ();
   osq_rsp_if rsp_if ();

   ordered_set_query_engine #(.CAPACITY(SET_CAPACITY)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   set_request_type  requests_to_send[$];
   set_answer_type   answers_due[$];
   set_request_type  next_request;

   osq_value_type members[SET_CAPACITY];
   int unsigned   member_count = 0;
   int unsigned   peak_count = 0;

   int unsigned requests_queued = 0;
   int unsigned requests_taken = 0;
   int unsigned responses_checked = 0;
   int unsigned errors = 0;
   int unsigned status_seen[4] = '{0, 0, 0, 0};
   int unsigned quiet_cycles = 0;

   logic req_fire = 1'b0;
   bit   no_idle = 1'b0;
   bit   hold_request = 1'b0;
   bit   hold_taken = 1'b0;
   int   hold_left = 0;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = ACT_INSERT;
      req_if.operand = '0;
      rsp_if.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   // Index of the first held value above the key, or at or above it.
   function automatic int unsigned first_index(osq_value_type key, bit strict);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = member_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (strict ? (members[mid] <= key) : (members[mid] < key)) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   function automatic void apply_request(input osq_action_type act,
                                         input osq_value_type opnd,
                                         output osq_value_type ans,
                                         output osq_status_type stat);
      int unsigned pos;
      int unsigned i;
      ans = '0;
      stat = STAT_OK;
      case (act)
         ACT_INSERT: begin
            pos = first_index(opnd, 1'b0);
            if (!(pos < member_count && members[pos] == opnd)) begin
               if (member_count >= SET_CAPACITY) begin
                  stat = STAT_FULL;
               end else begin
                  for (i = member_count; i > pos; i--) members[i] = members[i - 1];
                  members[pos] = opnd;
                  member_count++;
                  if (member_count > peak_count) peak_count = member_count;
               end
            end
         end
         ACT_DELETE: begin
            pos = first_index(opnd, 1'b0);
            if (pos < member_count && members[pos] == opnd) begin
               for (i = pos; i + 1 < member_count; i++) members[i] = members[i + 1];
               member_count--;
            end
         end
         default: begin
            if (member_count == 0) begin
               stat = STAT_EMPTY;
            end else if (act == ACT_MIN) begin
               ans = members[0];
            end else if (act == ACT_MAX) begin
               ans = members[member_count - 1];
            end else if (act == ACT_SUCC_STRICT || act == ACT_SUCC_EQ) begin
               pos = first_index(opnd, act == ACT_SUCC_STRICT);
               if (pos < member_count) ans = members[pos];
               else stat = STAT_NONE;
            end else begin
               pos = first_index(opnd, act == ACT_PRED_EQ);
               if (pos > 0) ans = members[pos - 1];
               else stat = STAT_NONE;
            end
         end
      endcase
   endfunction

   function automatic osq_value_type pick_operand();
      int unsigned roll;
      osq_value_type v;
      roll = $urandom_range(99);
      if (member_count != 0 && roll < 35) begin
         v = members[$urandom_range(member_count - 1)];
      end else if (member_count != 0 && roll < 55) begin
         v = members[$urandom_range(member_count - 1)] + ($urandom_range(1) ? 1 : -1);
      end else if (roll < 80) begin
         v = osq_value_type'($urandom_range(40)) - 20;
      end else if (roll < 90) begin
         case ($urandom_range(3))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = '0;
            default: v = VAL_ONES;
         endcase
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   function automatic osq_action_type pick_query();
      return osq_action_type'($urandom_range(ACT_PRED_EQ, ACT_MIN));
   endfunction

   task automatic offer(input osq_action_type act, input osq_value_type opnd);
      set_request_type r;
      while (requests_to_send.size() >= 4) @(negedge clock);
      r.action = act;
      r.operand = opnd;
      requests_to_send.push_back(r);
      requests_queued++;
   endtask

   task automatic wait_all_answered();
      while (requests_taken != requests_queued || answers_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic note_error(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // Request driver: a new transaction is presented once the last one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (requests_to_send.size() != 0 &&
             (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
            next_request = requests_to_send.pop_front();
            req_if.valid <= 1'b1;
            req_if.action <= next_request.action;
            req_if.operand <= next_request.operand;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response receiver with random stalls and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_if.ready <= 1'b0;
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD;
      end else begin
         rsp_if.ready <= no_idle || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin : observe
      set_answer_type due;
      set_answer_type head;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
               note_error($sformatf("unexpected response: answer %0d status %0d",
                                    rsp_if.answer, rsp_if.status));
            end else begin
               head = answers_due.pop_front();
               responses_checked++;
               status_seen[head.status]++;
               if (rsp_if.answer !== head.answer || rsp_if.status !== head.status) begin
                  note_error($sformatf(
                     "mismatch on action %0d operand %0d: expected answer %0d status %0d, %s",
                     head.action, head.operand, head.answer, head.status,
                     $sformatf("got answer %0d status %0d", rsp_if.answer, rsp_if.status)));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            due.action = req_if.action;
            due.operand = req_if.operand;
            apply_request(req_if.action, req_if.operand, due.answer, due.status);
            answers_due.push_back(due);
            requests_taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int n;
      int unsigned roll;
      osq_action_type act;
      osq_value_type opnd;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty set, value extremes, duplicates, absent deletes, missing neighbors.
      offer(ACT_MIN, '0);
      offer(ACT_SUCC_STRICT, VAL_MAX);
      offer(ACT_PRED_EQ, VAL_MIN);
      offer(ACT_DELETE, '0);
      offer(ACT_INSERT, VAL_MAX);
      offer(ACT_INSERT, VAL_MIN);
      offer(ACT_INSERT, '0);
      offer(ACT_INSERT, '0);
      offer(ACT_SUCC_STRICT, VAL_MAX);
      offer(ACT_PRED_STRICT, VAL_MIN);
      offer(ACT_SUCC_EQ, VAL_MAX);
      offer(ACT_PRED_EQ, VAL_MIN);
      offer(ACT_MIN, VAL_ALT_A);
      offer(ACT_MAX, VAL_ALT_B);
      offer(ACT_INSERT, VAL_ONES);
      offer(ACT_INSERT, VAL_ALT_A);
      offer(ACT_INSERT, VAL_ALT_B);
      offer(ACT_SUCC_STRICT, '0);
      offer(ACT_PRED_STRICT, '0);
      offer(ACT_DELETE, '0);
      offer(ACT_SUCC_EQ, '0);
      offer(ACT_PRED_EQ, '0);
      offer(ACT_DELETE, 32'sd5);
      offer(ACT_DELETE, VAL_MAX);
      offer(ACT_MAX, VAL_ONES);

      // Small, clustered set with frequent hits; the receiver holds off once.
      for (n = 0; n < 60; n++) begin
         roll = $urandom_range(99);
         if (roll < 30) act = ACT_INSERT;
         else if (roll < 50) act = ACT_DELETE;
         else act = pick_query();
         offer(act, pick_operand());
         if (n == 20) hold_request = 1'b1;
      end

      // The sender pauses until every response is back.
      wait_all_answered();

      // Fill the set to capacity, starting with a stretch of no stalls.
      no_idle = 1'b1;
      n = 0;
      while (member_count < SET_CAPACITY) begin
         roll = $urandom_range(99);
         if (roll < 98) begin
            act = ACT_INSERT;
            roll = $urandom_range(99);
            if (member_count != 0 && roll < 3) opnd = members[$urandom_range(member_count - 1)];
            else if (roll < 8) opnd = pick_operand();
            else opnd = $urandom;
         end else begin
            act = pick_query();
            opnd = pick_operand();
         end
         offer(act, opnd);
         n++;
         if (n == 200) no_idle = 1'b0;
      end
      no_idle = 1'b0;

      // Full set: new values are refused, duplicates and queries still answer.
      for (n = 0; n < 30; n++) begin
         roll = $urandom_range(99);
         if (roll < 50) offer(ACT_INSERT, $urandom);
         else if (roll < 70) offer(ACT_INSERT, pick_operand());
         else offer(pick_query(), pick_operand());
      end

      // Shrink the set again with deletes, mixed with queries and inserts.
      for (n = 0; n < 60; n++) begin
         roll = $urandom_range(99);
         if (roll < 50) offer(ACT_DELETE, pick_operand());
         else if (roll < 80) offer(pick_query(), pick_operand());
         else offer(ACT_INSERT, pick_operand());
      end

      wait_all_answered();
      repeat (2 * ENGINE_LATENCY) @(posedge clock);

      $display("Covered %0d requests and %0d responses; the set peaked at %0d of %0d values.",
               requests_taken, responses_checked, peak_count, SET_CAPACITY);
      $display("Responses by status: ok %0d, empty %0d, none %0d, full %0d; %0d errors.",
               status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_NONE],
               status_seen[STAT_FULL], errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
